### hdl/dsrh_pkg.sv
// shared types, constants and helpers of the date seeded range hash
// no dependencies

package dsrh_pkg;

  localparam int unsigned HashW = 32;

  // fnv-1a 32-bit offset basis and prime
  localparam logic [HashW-1:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [HashW-1:0] FnvPrime = 32'h0100_0193;

  // murmur3 fmix32 multipliers
  localparam logic [HashW-1:0] FmixMulA = 32'h85EB_CA6B;
  localparam logic [HashW-1:0] FmixMulB = 32'hC2B2_AE35;

  // words folded into the hash: year, month, day, low bound, high bound
  localparam int unsigned FnvSteps = 5;

  // swap stage, one stage per fnv step, three finalizer stages
  localparam int unsigned FrontStages = 1 + FnvSteps + 3;
  // one remainder bit per stage
  localparam int unsigned RemStages = HashW;
  // front stages, remainder stages, output register
  localparam int unsigned Latency = FrontStages + RemStages + 1;

  typedef struct packed {
    logic [6:0]       year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [HashW-1:0] lo;
    logic [HashW-1:0] hi;
    logic [HashW-1:0] h;
  } front_t;

  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] dividend;
    logic [HashW-1:0] divisor;
    logic [HashW-1:0] lo;
  } rem_req_t;

  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] rem;
    logic [HashW-1:0] lo;
  } rem_rsp_t;

  typedef struct packed {
    logic [HashW-1:0] rem;
    logic [HashW-1:0] dvd;
    logic [HashW-1:0] dvs;
    logic [HashW-1:0] lo;
  } rem_stage_t;

  // word folded in at a given fnv step
  function automatic logic [HashW-1:0] fnv_word(front_t s, int unsigned step);
    logic [HashW-1:0] w;
    case (step)
      0:       w = HashW'(s.year);
      1:       w = HashW'(s.month);
      2:       w = HashW'(s.day);
      3:       w = s.lo;
      default: w = s.hi;
    endcase
    return w;
  endfunction

endpackage

### hdl/dsrh_rem_pipe.sv
// pipelined restoring remainder unit, one dividend bit per stage
// depends on dsrh_pkg

module dsrh_rem_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsrh_pkg::rem_req_t req_i,
  output dsrh_pkg::rem_rsp_t rsp_o
);

  logic                 vld_q [dsrh_pkg::RemStages];
  dsrh_pkg::rem_stage_t stg_q [dsrh_pkg::RemStages];

  for (genvar k = 0; k < dsrh_pkg::RemStages; k++) begin : g_stage
    dsrh_pkg::rem_stage_t src;
    dsrh_pkg::rem_stage_t nxt;
    logic                 src_vld;
    logic [dsrh_pkg::HashW:0] trial;
    logic [dsrh_pkg::HashW:0] diff;

    if (k == 0) begin : g_first
      assign src_vld  = req_i.valid;
      assign src.rem  = '0;
      assign src.dvd  = req_i.dividend;
      assign src.dvs  = req_i.divisor;
      assign src.lo   = req_i.lo;
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      assign src     = stg_q[k-1];
    end

    // shift in the next dividend bit, subtract if it fits
    assign trial = {src.rem, src.dvd[dsrh_pkg::HashW-1]};
    assign diff  = trial - {1'b0, src.dvs};

    always_comb begin
      nxt     = src;
      nxt.rem = diff[dsrh_pkg::HashW] ? trial[dsrh_pkg::HashW-1:0]
                                      : diff[dsrh_pkg::HashW-1:0];
      nxt.dvd = {src.dvd[dsrh_pkg::HashW-2:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k] <= nxt;
    end
  end

  assign rsp_o.valid = vld_q[dsrh_pkg::RemStages-1];
  assign rsp_o.rem   = stg_q[dsrh_pkg::RemStages-1].rem;
  assign rsp_o.lo    = stg_q[dsrh_pkg::RemStages-1].lo;

endmodule

### hdl/date_seeded_range_hash.sv
// top level of the date seeded range hash: fnv-1a fold, fmix32, range map
// depends on dsrh_pkg and dsrh_rem_pipe

// pipeline: an accepted request reaches its valid_o strobe through
// 1 bound swap + 5 fnv steps + 3 finalizer/span stages + 32 remainder stages
// + 1 output register, one constant multiply at most per register stage
// throughput: one request per cycle; busy stays low, the pipeline never stalls
// reset (rst_ni low, asynchronous) clears all stage valid bits; data regs keep
// whatever they hold, results never wait since the receiver cannot stall

module date_seeded_range_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  output logic [31:0] value_o,
  output logic        valid_o
);

  // request acceptance, nothing ever holds the pipeline
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------------
  // stage 0: order the bounds, load the offset basis
  // ---------------------------------------------------------------------------
  logic             sw_vld_q;
  dsrh_pkg::front_t sw_d, sw_q;
  logic             swap;

  assign swap = range_low_i > range_high_i;

  always_comb begin
    sw_d.year  = year_i;
    sw_d.month = month_i;
    sw_d.day   = day_of_month_i;
    sw_d.lo    = swap ? range_high_i : range_low_i;
    sw_d.hi    = swap ? range_low_i  : range_high_i;
    sw_d.h     = dsrh_pkg::FnvBasis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_vld_q <= 1'b0;
    end else begin
      sw_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_q <= sw_d;
  end

  // ---------------------------------------------------------------------------
  // fnv-1a steps: one xor and one multiply by the prime per stage
  // ---------------------------------------------------------------------------
  logic             fnv_vld_q [dsrh_pkg::FnvSteps];
  dsrh_pkg::front_t fnv_q     [dsrh_pkg::FnvSteps];

  for (genvar k = 0; k < dsrh_pkg::FnvSteps; k++) begin : g_fnv
    dsrh_pkg::front_t src;
    dsrh_pkg::front_t nxt;
    logic             src_vld;

    if (k == 0) begin : g_first
      assign src_vld = sw_vld_q;
      assign src     = sw_q;
    end else begin : g_next
      assign src_vld = fnv_vld_q[k-1];
      assign src     = fnv_q[k-1];
    end

    always_comb begin
      nxt   = src;
      nxt.h = (src.h ^ dsrh_pkg::fnv_word(src, k)) * dsrh_pkg::FnvPrime;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fnv_vld_q[k] <= 1'b0;
      end else begin
        fnv_vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      fnv_q[k] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // fmix32 finalizer, split over three stages
  // ---------------------------------------------------------------------------
  logic             fm1_vld_q, fm2_vld_q, fm3_vld_q;
  logic [31:0]      fm1_d, fm1_q, fm2_d, fm2_q;
  logic [31:0]      lo1_q, hi1_q, lo2_q, hi2_q;
  logic [31:0]      fin;
  dsrh_pkg::front_t fnv_last;

  assign fnv_last = fnv_q[dsrh_pkg::FnvSteps-1];

  // h ^= h >> 16; h *= a
  assign fm1_d = (fnv_last.h ^ (fnv_last.h >> 16)) * dsrh_pkg::FmixMulA;
  // h ^= h >> 13; h *= b
  assign fm2_d = (fm1_q ^ (fm1_q >> 13)) * dsrh_pkg::FmixMulB;
  // h ^= h >> 16
  assign fin   = fm2_q ^ (fm2_q >> 16);

  // request into the remainder unit, registered
  logic [31:0]      rq_h_q, rq_span_q, rq_lo_q;
  dsrh_pkg::rem_req_t rem_req;
  dsrh_pkg::rem_rsp_t rem_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm1_vld_q <= 1'b0;
      fm2_vld_q <= 1'b0;
      fm3_vld_q <= 1'b0;
    end else begin
      fm1_vld_q <= fnv_vld_q[dsrh_pkg::FnvSteps-1];
      fm2_vld_q <= fm1_vld_q;
      fm3_vld_q <= fm2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fm1_q     <= fm1_d;
    lo1_q     <= fnv_last.lo;
    hi1_q     <= fnv_last.hi;
    fm2_q     <= fm2_d;
    lo2_q     <= lo1_q;
    hi2_q     <= hi1_q;
    rq_h_q    <= fin;
    // span wraps to zero for the full 32-bit range
    rq_span_q <= hi2_q - lo2_q + 32'd1;
    rq_lo_q   <= lo2_q;
  end

  assign rem_req.valid    = fm3_vld_q;
  assign rem_req.dividend = rq_h_q;
  assign rem_req.divisor  = rq_span_q;
  assign rem_req.lo       = rq_lo_q;

  // ---------------------------------------------------------------------------
  // hash mod span, one quotient bit per stage
  // with a zero span (full range) no step ever subtracts, so the remainder
  // comes out as the hash itself and low is zero: the hash passes unchanged
  // ---------------------------------------------------------------------------
  dsrh_rem_pipe u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // ---------------------------------------------------------------------------
  // output register: low bound plus remainder, one-cycle strobe
  // ---------------------------------------------------------------------------
  logic        out_vld_q;
  logic [31:0] out_val_d, out_val_q;

  assign out_val_d = rem_rsp.lo + rem_rsp.rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= rem_rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
  end

  assign value_o = out_val_q;
  assign valid_o = out_vld_q;

endmodule

### hdl/dsrh_checker.sv
// port-level checker for the date seeded range hash, bound to the top level
// depends on dsrh_pkg and date_seeded_range_hash

module dsrh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [31:0] range_low_i,
  input logic [31:0] range_high_i,
  input logic [31:0] value_o,
  input logic        valid_o
);

  logic        req_acc;
  logic [31:0] bound_min, bound_max;

  assign req_acc   = start && !busy;
  assign bound_min = (range_low_i > range_high_i) ? range_high_i : range_low_i;
  assign bound_max = (range_low_i > range_high_i) ? range_low_i  : range_high_i;

  // every accepted request yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##(dsrh_pkg::Latency) valid_o)
    else $error("accepted request produced no result");

  // no result without a request the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_acc |-> ##(dsrh_pkg::Latency) !valid_o)
    else $error("result strobe without a request");

  // a result lies inside the ordered bounds of its request
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (value_o >= $past(bound_min, dsrh_pkg::Latency)) &&
                (value_o <= $past(bound_max, dsrh_pkg::Latency)))
    else $error("result outside requested range");

  // the pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind date_seeded_range_hash dsrh_checker u_dsrh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .range_low_i  (range_low_i),
  .range_high_i (range_high_i),
  .value_o      (value_o),
  .valid_o      (valid_o)
);
